// File: rtl/mrs_pkg.sv
`timescale 1ns / 1ps

package mrs_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FN_RD_COILS    = 8'd1;
  localparam logic [7:0] FN_RD_DISCRETE = 8'd2;
  localparam logic [7:0] FN_RD_HOLDING  = 8'd3;
  localparam logic [7:0] FN_RD_INPUT    = 8'd4;
  localparam logic [7:0] FN_WR_COIL     = 8'd5;
  localparam logic [7:0] FN_WR_HOLDING  = 8'd6;

  localparam logic [7:0] EXC_FLAG      = 8'h80;
  localparam logic [1:0] EXC_FUNCTION  = 2'd1;
  localparam logic [1:0] EXC_ADDRESS   = 2'd2;
  localparam logic [1:0] EXC_VALUE     = 2'd3;

  localparam logic [15:0] COIL_ON  = 16'hFF00;
  localparam logic [15:0] COIL_OFF = 16'h0000;

  localparam logic [1:0] OP_RX_BYTE  = 2'd0;
  localparam logic [1:0] OP_LOC_IREG = 2'd1;
  localparam logic [1:0] OP_LOC_DISC = 2'd2;

  // one bit step of the reflected CRC-16
  function automatic logic [15:0] crc_step(input logic [15:0] c);
    crc_step = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

// File: rtl/mrs_ram.sv
`timescale 1ns / 1ps

module mrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/modbus_rtu_slave_register_server.sv
`timescale 1ns / 1ps

// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// in       | in_valid/in_stall  | operation, rx_byte, frame_end, local_addr,
//          |                    | local_value
// out      | out_valid/out_stall| tx_bytes, tx_count, tx_last
// cfg      | cfg_wr_en          | cfg_wr_data (unit_id)
//
// Local writes and the first two frame bytes are taken in S_IDLE; later frame
// bytes also pass S_FEED (one bit of the shared CRC shifter per cycle).
// At frame end: S_CHECK, then per reply byte S_NEXT, S_CRCB and S_PUSH (register
// reads add a RAM read state, bit reads S_BITS/S_BITW); CRC bytes skip S_CRCB.
// Tables reset to zero through per-entry valid flops; no clearing pass.
// out_stall holds the sequencer only when a word must leave the packer.
module modbus_rtu_slave_register_server #(
  parameter int TABLE_DEPTH = mrs_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  input  logic [5:0]  local_addr,
  input  logic [15:0] local_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] tx_bytes,
  output logic [2:0]  tx_count,
  output logic        tx_last
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FEED  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_NEXT  = 4'd3;
  localparam logic [3:0] S_RDW   = 4'd4;
  localparam logic [3:0] S_BITS  = 4'd5;
  localparam logic [3:0] S_BITW  = 4'd6;
  localparam logic [3:0] S_CRCB  = 4'd7;
  localparam logic [3:0] S_PUSH  = 4'd8;

  localparam logic [1:0] K_EXC  = 2'd0;
  localparam logic [1:0] K_ECHO = 2'd1;
  localparam logic [1:0] K_REG  = 2'd2;
  localparam logic [1:0] K_BIT  = 2'd3;

  logic [3:0]  state;
  logic [7:0]  unit_id;
  logic [15:0] crc;
  logic [15:0] tail;
  logic [3:0]  byte_counter;
  logic [7:0]  hdr [6];
  logic        fend_q;
  logic [1:0]  kind;
  logic [1:0]  code;
  logic [7:0]  n;
  logic [7:0]  pos;
  logic [6:0]  idx;
  logic [2:0]  jcnt;
  logic [2:0]  stepc;
  logic [7:0]  tx_b;
  logic [7:0]  word_lo;
  logic [23:0] acc;
  logic [1:0]  acc_cnt;
  logic        rd_ok;

  logic [TABLE_DEPTH-1:0] hold_v, inp_v, coil_v, disc_v;

  logic        in_acc;
  logic [7:0]  unit, fn;
  logic [15:0] addr16, val16;
  logic        bc, addr_bad, cnt_bad;
  logic [7:0]  nb;
  logic        chk_drop, wr_hold, wr_coil;
  logic [1:0]  chk_kind, chk_code;
  logic [AW-1:0] raddr, laddr;
  logic        loc_ok;
  logic [15:0] hold_q, inp_q;
  logic [0:0]  coil_q, disc_q;
  logic [15:0] val_rd;
  logic        bit_rd;
  logic        sel_valid;
  logic        last, flush, can_push, push;
  logic [15:0] crc_in;
  logic [7:0]  head_b;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign unit   = hdr[0];
  assign fn     = hdr[1];
  assign addr16 = {hdr[2], hdr[3]};
  assign val16  = {hdr[4], hdr[5]};
  assign bc     = (unit == 8'd0);
  assign addr_bad = ({1'b0, addr16} >= DEPTH17);
  assign cnt_bad  = (val16 == 16'd0) || addr_bad ||
                    ({1'b0, val16} > (DEPTH17 - {1'b0, addr16}));
  assign nb = 8'(({1'b0, val16[6:0]} + 8'd7) >> 3);

  assign raddr  = addr16[AW-1:0] + idx[AW-1:0];
  assign laddr  = local_addr[AW-1:0];
  assign loc_ok = ({1'b0, local_addr} < 7'(TABLE_DEPTH));

  always_comb begin
    chk_drop = 1'b1;
    chk_kind = K_EXC;
    chk_code = mrs_pkg::EXC_FUNCTION;
    wr_hold  = 1'b0;
    wr_coil  = 1'b0;
    if (byte_counter >= 4'd8 && (unit == unit_id || bc) && tail == crc &&
        !(bc && fn != mrs_pkg::FN_WR_COIL && fn != mrs_pkg::FN_WR_HOLDING)) begin
      if (fn >= mrs_pkg::FN_RD_COILS && fn <= mrs_pkg::FN_RD_INPUT) begin
        if (byte_counter == 4'd8) begin
          chk_drop = 1'b0;
          if (cnt_bad) begin
            chk_code = mrs_pkg::EXC_ADDRESS;
          end else begin
            chk_kind = (fn <= mrs_pkg::FN_RD_DISCRETE) ? K_BIT : K_REG;
          end
        end
      end else if (fn == mrs_pkg::FN_WR_COIL || fn == mrs_pkg::FN_WR_HOLDING) begin
        if (byte_counter == 4'd8) begin
          chk_drop = bc;
          if (addr_bad) begin
            chk_code = mrs_pkg::EXC_ADDRESS;
          end else if (fn == mrs_pkg::FN_WR_COIL && val16 != mrs_pkg::COIL_ON &&
                       val16 != mrs_pkg::COIL_OFF) begin
            chk_code = mrs_pkg::EXC_VALUE;
          end else begin
            chk_kind = K_ECHO;
            wr_coil  = (fn == mrs_pkg::FN_WR_COIL);
            wr_hold  = (fn == mrs_pkg::FN_WR_HOLDING);
          end
        end
      end else begin
        chk_drop = 1'b0;
      end
    end
  end

  mrs_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_hold (
    .clk(clk), .we(state == S_CHECK && wr_hold), .waddr(addr16[AW-1:0]),
    .wdata(val16), .raddr(raddr), .rdata(hold_q)
  );
  mrs_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_inp (
    .clk(clk), .we(in_acc && operation == mrs_pkg::OP_LOC_IREG && loc_ok),
    .waddr(laddr), .wdata(local_value), .raddr(raddr), .rdata(inp_q)
  );
  mrs_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_coil (
    .clk(clk), .we(state == S_CHECK && wr_coil), .waddr(addr16[AW-1:0]),
    .wdata(val16 == mrs_pkg::COIL_ON), .raddr(raddr), .rdata(coil_q)
  );
  mrs_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_disc (
    .clk(clk), .we(in_acc && operation == mrs_pkg::OP_LOC_DISC && loc_ok),
    .waddr(laddr), .wdata(local_value != 16'd0), .raddr(raddr), .rdata(disc_q)
  );

  always_comb begin
    case (fn)
      mrs_pkg::FN_RD_COILS:    sel_valid = coil_v[raddr];
      mrs_pkg::FN_RD_DISCRETE: sel_valid = disc_v[raddr];
      mrs_pkg::FN_RD_HOLDING:  sel_valid = hold_v[raddr];
      default:                 sel_valid = inp_v[raddr];
    endcase
  end

  assign val_rd = rd_ok ? ((fn == mrs_pkg::FN_RD_HOLDING) ? hold_q : inp_q) : 16'd0;
  assign bit_rd = rd_ok && ((fn == mrs_pkg::FN_RD_COILS) ? coil_q[0] : disc_q[0]);

  always_comb begin
    head_b = unit;
    case (kind)
      K_EXC: begin
        if (pos == 8'd1) head_b = fn | mrs_pkg::EXC_FLAG;
        else if (pos == 8'd2) head_b = {6'd0, code};
      end
      K_ECHO: head_b = hdr[pos[2:0]];
      K_REG: begin
        if (pos == 8'd1) head_b = fn;
        else if (pos == 8'd2) head_b = {val16[6:0], 1'b0};
      end
      default: begin
        if (pos == 8'd1) head_b = fn;
        else if (pos == 8'd2) head_b = nb;
      end
    endcase
  end

  // shared CRC shifter: first step folds the byte in
  assign crc_in = (stepc == 3'd0) ? (crc ^ {8'd0, tx_b}) : crc;

  assign last     = ({1'b0, pos} == ({1'b0, n} + 9'd1));
  assign flush    = (acc_cnt == 2'd3) || last;
  assign can_push = !flush || !out_valid || !out_stall;
  assign push     = (state == S_PUSH) && can_push;

  always_ff @(posedge clk) begin
    rd_ok <= sel_valid;
    if (rst) begin
      state        <= S_IDLE;
      unit_id      <= 8'd1;
      crc          <= mrs_pkg::CRC_INIT;
      tail         <= 16'd0;
      byte_counter <= 4'd0;
      hold_v       <= '0;
      inp_v        <= '0;
      coil_v       <= '0;
      disc_v       <= '0;
    end else begin
      if (cfg_wr_en) begin
        unit_id <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (operation)
              mrs_pkg::OP_RX_BYTE: begin
                fend_q <= frame_end;
                tail   <= {rx_byte, tail[15:8]};
                if (byte_counter < 4'd6) hdr[byte_counter[2:0]] <= rx_byte;
                if (byte_counter != 4'd15) byte_counter <= byte_counter + 4'd1;
                if (byte_counter >= 4'd2) begin
                  tx_b  <= tail[7:0];
                  stepc <= 3'd0;
                  state <= S_FEED;
                end else if (frame_end) begin
                  state <= S_CHECK;
                end
              end
              mrs_pkg::OP_LOC_IREG: if (loc_ok) inp_v[laddr] <= 1'b1;
              mrs_pkg::OP_LOC_DISC: if (loc_ok) disc_v[laddr] <= 1'b1;
              default: ;
            endcase
          end
        end
        S_FEED: begin
          crc   <= mrs_pkg::crc_step(crc_in);
          stepc <= stepc + 3'd1;
          if (stepc == 3'd7) state <= fend_q ? S_CHECK : S_IDLE;
        end
        S_CHECK: begin
          byte_counter <= 4'd0;
          tail         <= 16'd0;
          crc          <= mrs_pkg::CRC_INIT;
          if (wr_hold) hold_v[addr16[AW-1:0]] <= 1'b1;
          if (wr_coil) coil_v[addr16[AW-1:0]] <= 1'b1;
          kind <= chk_kind;
          code <= chk_code;
          pos  <= 8'd0;
          idx  <= 7'd0;
          case (chk_kind)
            K_EXC:   n <= 8'd3;
            K_ECHO:  n <= 8'd6;
            K_REG:   n <= 8'd3 + {val16[6:0], 1'b0};
            default: n <= 8'd3 + nb;
          endcase
          state <= chk_drop ? S_IDLE : S_NEXT;
        end
        S_NEXT: begin
          stepc <= 3'd0;
          if (pos < n) begin
            if (kind == K_REG && pos >= 8'd3) begin
              if (pos[0]) begin
                state <= S_RDW;
              end else begin
                tx_b  <= word_lo;
                idx   <= idx + 7'd1;
                state <= S_CRCB;
              end
            end else if (kind == K_BIT && pos >= 8'd3) begin
              tx_b  <= 8'd0;
              jcnt  <= 3'd0;
              state <= S_BITS;
            end else begin
              tx_b  <= head_b;
              state <= S_CRCB;
            end
          end else begin
            tx_b  <= (pos == n) ? crc[7:0] : crc[15:8];
            state <= S_PUSH;
          end
        end
        S_RDW: begin
          word_lo <= val_rd[7:0];
          tx_b    <= val_rd[15:8];
          state   <= S_CRCB;
        end
        S_BITS: begin
          if ({9'd0, idx} < val16) begin
            state <= S_BITW;
          end else if (jcnt == 3'd7) begin
            state <= S_CRCB;
          end else begin
            jcnt <= jcnt + 3'd1;
          end
        end
        S_BITW: begin
          tx_b[jcnt] <= bit_rd;
          idx        <= idx + 7'd1;
          jcnt       <= jcnt + 3'd1;
          state      <= (jcnt == 3'd7) ? S_CRCB : S_BITS;
        end
        S_CRCB: begin
          crc   <= mrs_pkg::crc_step(crc_in);
          stepc <= stepc + 3'd1;
          if (stepc == 3'd7) state <= S_PUSH;
        end
        S_PUSH: begin
          if (can_push) begin
            pos <= pos + 8'd1;
            if (last) begin
              crc   <= mrs_pkg::CRC_INIT;
              state <= S_IDLE;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // byte packer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= 24'd0;
      acc_cnt   <= 2'd0;
    end else begin
      if (push && flush) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (push) begin
        if (flush) begin
          tx_bytes  <= {8'd0, acc} | ({24'd0, tx_b} << {acc_cnt, 3'd0});
          tx_count  <= {1'b0, acc_cnt} + 3'd1;
          tx_last   <= last;
          acc       <= 24'd0;
          acc_cnt   <= 2'd0;
        end else begin
          acc[{acc_cnt, 3'd0} +: 8] <= tx_b;
          acc_cnt <= acc_cnt + 2'd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tx_count != 3'd0 && tx_count <= 3'd4))
    else $error("tx_count out of range");

  a_check_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |=> (byte_counter == 4'd0 && tail == 16'd0))
    else $error("frame state not cleared after check");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_NEXT || state == S_PUSH) |-> ({1'b0, pos} <= {1'b0, n} + 9'd1))
    else $error("reply position past frame end");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (push && last) |=> (acc_cnt == 2'd0 && state == S_IDLE))
    else $error("packer not empty after last byte");
`endif

endmodule
